### sv/crs_pkg.sv
// Shared types, constants and GF(2^8) arithmetic for the Cauchy RS parity encoder.
package crs_pkg;

  localparam logic [8:0] GF_POLY = 9'h11D;
  localparam int         GF_SIZE = 256;
  localparam int         BYTE_W  = 8;

  // Configuration register indexes
  localparam int         CFG_IW           = 1;
  localparam logic [0:0] REG_DATA_SHARDS  = 1'b0;
  localparam logic [0:0] REG_TOTAL_SHARDS = 1'b1;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;

  typedef logic [BYTE_W-1:0] inv_tab_t [GF_SIZE];

  // One classified data byte as it travels from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] y;        // (n + shard position) mod 256
    logic              col_end;  // last byte of its column
    logic              blk;      // block end flag of this byte
  } crs_item_t;

  // Shift-and-reduce multiply, eight narrow steps
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0]   x;
    logic [BYTE_W-1:0] r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) r = r ^ x[BYTE_W-1:0];
      x = x << 1;
      if (x[BYTE_W]) x = x ^ GF_POLY;
    end
    return r;
  endfunction

  // Inverse table built at elaboration as a^254; zero maps to zero
  function automatic inv_tab_t gen_inv();
    inv_tab_t          t;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] e;
    for (int a = 0; a < GF_SIZE; a++) begin
      r = 8'h01;
      b = 8'(a);
      e = 8'd254;
      for (int i = 0; i < BYTE_W; i++) begin
        if (e[0]) r = gf_mul(r, b);
        b = gf_mul(b, b);
        e = e >> 1;
      end
      t[a] = r;
    end
    return t;
  endfunction

  localparam inv_tab_t GF_INV = gen_inv();

endpackage

### sv/cauchy_rs_parity_encoder.sv
// Top level of the Cauchy Reed-Solomon GF(2^8) parity encoder.
//
// Usage: data bytes enter on the s_ stream, one per request, column by
// column in shard order; s_tlast marks bytes of the block's last column.
// Each byte is multiplied in parallel GF lanes by its Cauchy coefficient
// and folded into every parity accumulator. When a column completes, its
// n-k parity bytes leave on the m_ stream one per request, in row order,
// with m_tlast on the final row and m_tuser carrying the block end flag.
// Throughput: one data byte per cycle; a column yields n-k results, so
// when k < n-k the output port (one result per cycle) sets the pace and
// the queue between front and lanes fills, dropping s_tready.
// Path: a column's last byte reaches its first parity byte through the queue
// write, coefficient lookup, accumulate and snapshot, and output register.
// Reset: k=1, n=2, accumulators and shard position cleared, no output
// pending. A stalled receiver holds the output register and the snapshot;
// the lanes keep accumulating the next column until its end is reached.
// Configuration: write k (index 0) or n (index 1) only while idle; each
// write restarts the column. Invalid settings make the block drop input.
module cauchy_rs_parity_encoder #(
  parameter int MAX_PARITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input bytes
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,   // block_end
  // parity results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [7:0] parity_byte, [11:8] parity_index
  output logic                          m_tlast,   // last_parity
  output logic                          m_tuser,   // block_last
  // configuration writes
  input  logic                          cfg_we,
  input  logic [crs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic [7:0] k;
  logic [7:0] n;
  logic [7:0] parity_cnt;
  logic       cfg_ok;

  logic                q_full;
  logic                push;
  crs_pkg::crs_item_t  push_item;
  logic                q_valid;
  crs_pkg::crs_item_t  q_item;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 8'd1;
      n <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crs_pkg::REG_DATA_SHARDS:  k <= cfg_data;
        crs_pkg::REG_TOTAL_SHARDS: n <= cfg_data;
      endcase
    end
  end

  // parity row count and validity of the current settings
  assign parity_cnt = n - k;
  assign cfg_ok     = (k != 8'd0) && (n >= k) && (int'(parity_cnt) <= MAX_PARITY);

  crs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_clear (cfg_we),
    .cfg_ok    (cfg_ok),
    .k         (k),
    .n         (n),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  crs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  crs_back #(
    .MAX_PARITY (MAX_PARITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_we),
    .k          (k),
    .parity_cnt (parity_cnt),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

### sv/crs_front.sv
// Input side: accepts data bytes, tracks the shard position and classifies each byte.
module crs_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [7:0] data_byte
  input  logic                    s_tlast,   // block_end
  input  logic                    cfg_clear,
  input  logic                    cfg_ok,
  input  logic [7:0]              k,
  input  logic [7:0]              n,
  input  logic                    q_full,
  output logic                    push,
  output crs_pkg::crs_item_t      push_item
);

  logic [7:0] shard_pos;
  logic       col_end;

  assign s_tready = !q_full;
  // drop bytes while the configuration is unusable
  assign push     = s_tvalid && s_tready && cfg_ok;
  assign col_end  = ({1'b0, shard_pos} + 9'd1) >= {1'b0, k};

  always_comb begin
    push_item.data    = s_tdata;
    push_item.y       = n + shard_pos;
    push_item.col_end = col_end;
    push_item.blk     = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      shard_pos <= '0;
    end else if (push) begin
      shard_pos <= col_end ? '0 : shard_pos + 8'd1;
    end
  end

endmodule

### sv/crs_fifo.sv
// Short queue of classified bytes between the front and the parity lanes.
module crs_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crs_pkg::crs_item_t  push_item,
  output logic                full,
  output logic                q_valid,
  output crs_pkg::crs_item_t  q_item,
  input  logic                pop
);

  localparam int PW = $clog2(crs_pkg::QDEPTH);
  localparam int CW = $clog2(crs_pkg::QDEPTH + 1);

  crs_pkg::crs_item_t slots [crs_pkg::QDEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [CW-1:0]      count;

  assign full    = count == CW'(crs_pkg::QDEPTH);
  assign q_valid = count != '0;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(crs_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(crs_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

### sv/crs_back.sv
// Parity lanes: coefficient lookup, multiply-accumulate, column snapshot and result drain.
module crs_back #(
  parameter int MAX_PARITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  logic [7:0]          k,
  input  logic [7:0]          parity_cnt,
  input  logic                q_valid,
  input  crs_pkg::crs_item_t  q_item,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // [7:0] parity_byte, [11:8] parity_index, rest zero
  output logic                m_tlast,   // last_parity
  output logic                m_tuser    // block_last
);

  localparam int CW = $clog2(MAX_PARITY + 1);

  // stage 1: coefficients per lane
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_col_end;
  logic       s1_blk;
  logic [7:0] coef [MAX_PARITY];

  // stage 2: accumulators and snapshot
  logic [7:0] acc      [MAX_PARITY];
  logic [7:0] acc_next [MAX_PARITY];
  logic [7:0] snap     [MAX_PARITY];

  logic [CW-1:0] em_left;
  logic [CW-1:0] em_idx;
  logic          em_blk;
  logic          busy;
  logic          fire;
  logic          s1_load;
  logic          out_free;
  logic          shift;
  logic          last_shift;

  assign busy       = em_left != '0;
  assign out_free   = !m_tvalid || m_tready;
  assign shift      = busy && out_free;
  assign last_shift = shift && (em_left == CW'(1));
  // a column end waits until the previous snapshot drains; it may go in the cycle of the last shift
  assign fire       = s1_valid && !(s1_col_end && busy && !last_shift);
  assign s1_load    = !s1_valid || fire;
  assign q_pop      = q_valid && s1_load;

  always_comb begin
    for (int p = 0; p < MAX_PARITY; p++) begin
      acc_next[p] = acc[p] ^ crs_pkg::gf_mul(coef[p], s1_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_data    <= q_item.data;
      s1_col_end <= q_item.col_end;
      s1_blk     <= q_item.blk;
      for (int p = 0; p < MAX_PARITY; p++) begin
        coef[p] <= crs_pkg::GF_INV[(k + 8'(p)) ^ q_item.y];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      for (int p = 0; p < MAX_PARITY; p++) acc[p] <= '0;
    end else if (fire) begin
      for (int p = 0; p < MAX_PARITY; p++) begin
        acc[p] <= s1_col_end ? '0 : acc_next[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_left  <= '0;
      em_idx   <= '0;
      em_blk   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire && s1_col_end) begin
        em_left <= CW'(parity_cnt);
        em_idx  <= '0;
        em_blk  <= s1_blk;
      end else if (shift) begin
        em_left <= em_left - 1'b1;
        em_idx  <= em_idx + 1'b1;
      end
      if (shift)         m_tvalid <= 1'b1;
      else if (out_free) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_col_end) begin
      for (int p = 0; p < MAX_PARITY; p++) snap[p] <= acc_next[p];
    end else if (shift) begin
      for (int p = 0; p < MAX_PARITY - 1; p++) snap[p] <= snap[p + 1];
      snap[MAX_PARITY - 1] <= '0;
    end
    if (shift) begin
      m_tdata <= {4'b0000, 4'(em_idx), snap[0]};
      m_tlast <= em_left == CW'(1);
      m_tuser <= em_blk;
    end
  end

endmodule

### sim/parity_scoreboard_pkg.sv
// Scoreboard for the Cauchy RS parity encoder: GF(2^8) parity predictor and result checks.
package parity_scoreboard_pkg;

  typedef struct packed {
    logic [7:0] value;
    logic [3:0] row;
    logic       fin;
    logic       blk;
  } parity_rec_t;

  class parity_scoreboard;
    int          max_rows;
    logic [7:0]  k_reg;
    logic [7:0]  n_reg;
    logic [7:0]  acc [16];
    int          pos;
    logic        blk_seen;
    logic [7:0]  recip_tab [256];
    parity_rec_t due_q [$];
    int          errors;
    int          checked;
    int          columns;
    int          writes;

    function new(input int rows_max);
      max_rows = rows_max;
      errors   = 0;
      checked  = 0;
      columns  = 0;
      writes   = 0;
      k_reg    = 8'd1;
      n_reg    = 8'd2;
      blk_seen = 1'b0;
      clear_column();
      // Build reciprocals by search; zero has none and maps to zero
      recip_tab[0] = 8'h00;
      for (int a = 1; a < 256; a++)
        for (int b = 1; b < 256; b++)
          if (gf_times(8'(a), 8'(b)) == 8'h01) recip_tab[a] = 8'(b);
    endfunction

    // Carry-less multiply, then fold bits 14..8 down with x^8 = x^4+x^3+x^2+1
    function logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [14:0] prod;
      prod = '0;
      for (int i = 0; i < 8; i++)
        if (b[i]) prod = prod ^ (15'(a) << i);
      for (int i = 14; i >= 8; i--)
        if (prod[i]) prod = prod ^ (15'h11D << (i - 8));
      return prod[7:0];
    endfunction

    function void clear_column();
      foreach (acc[i]) acc[i] = 8'h00;
      pos = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_config(input logic [0:0] idx, input logic [7:0] val);
      if (idx == crs_pkg::REG_DATA_SHARDS) k_reg = val;
      else n_reg = val;
      clear_column();
      writes++;
    endfunction

    // Fold one accepted byte into every parity row; close the column on its k-th byte
    function void note_input(input logic [7:0] d, input logic l);
      int          k;
      int          n;
      int          rows;
      logic [7:0]  coef;
      parity_rec_t rec;
      k = k_reg;
      n = n_reg;
      if (k < 1 || n < k || n - k > max_rows) return;
      rows = n - k;
      blk_seen = l;
      for (int p = 0; p < rows; p++) begin
        coef = recip_tab[8'(k + p) ^ 8'(n + pos)];
        acc[p] = acc[p] ^ gf_times(coef, d);
      end
      if (pos + 1 >= k) begin
        for (int p = 0; p < rows; p++) begin
          rec.value = acc[p];
          rec.row   = 4'(p);
          rec.fin   = (p + 1 == rows);
          rec.blk   = blk_seen;
          due_q = {due_q, rec};
        end
        columns++;
        clear_column();
      end else begin
        pos++;
      end
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(input logic [15:0] word, input logic fin, input logic blk);
      parity_rec_t want;
      if (due_q.size() == 0) begin
        report_mismatch("unrequested parity result", word, 0);
        return;
      end
      want = due_q.pop_front();
      if (word[7:0] !== want.value) report_mismatch("parity_byte", word[7:0], want.value);
      if (word[11:8] !== want.row) report_mismatch("parity_index", word[11:8], want.row);
      if (word[15:12] !== 4'h0) report_mismatch("tdata padding", word[15:12], 0);
      if (fin !== want.fin) report_mismatch("last_parity", fin, want.fin);
      if (blk !== want.blk) report_mismatch("block_last", blk, want.blk);
      checked++;
    endtask
  endclass

endpackage

### sim/cauchy_rs_parity_encoder_tb.sv
// Self-checking testbench for the Cauchy Reed-Solomon GF(2^8) parity encoder.
module cauchy_rs_parity_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARITY_ROWS_MAX = 16;
  localparam int SETTLE_CYCLES   = 20;   // idle margin after a drain for the pipe to empty
  localparam int RANDOM_BYTES    = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = crs_pkg::REG_DATA_SHARDS;
  logic [7:0]  cfg_data = 8'h00;

  parity_scoreboard_pkg::parity_scoreboard sb;
  bit               steady_feed = 1'b0;   // sender runs back to back while set
  int               fed = 0;              // random data bytes accepted under a valid setup

  cauchy_rs_parity_encoder #(.MAX_PARITY(PARITY_ROWS_MAX)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Gap length in cycles: none when steady, else mostly none or short, now and then long
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Receiver pacing: ready runs broken by stalls, with long stall-free stretches
  initial begin : sink_pace
    int span;
    @(posedge clk);
    forever begin
      span = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(6, 1);
      m_tready <= 1'b1;
      repeat (span) @(posedge clk);
      span = pick_gap(1'b0);
      if (span > 0) begin
        m_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Check every parity request that completes at this edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
  end

  // Offer one data byte, hold it until the request is taken, then score it
  task automatic send_byte(input logic [7:0] d, input logic l);
    int g;
    g = pick_gap(steady_feed);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(d, l);
  endtask

  // Drop valid and hold off until every predicted parity byte has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drain, then let a column with no results (or dropped input) clear the pipe
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.note_config(idx, val);
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [7:0] k, input logic [7:0] n);
    settle();
    write_reg(crs_pkg::REG_DATA_SHARDS, k);
    write_reg(crs_pkg::REG_TOTAL_SHARDS, n);
  endtask

  initial begin : stimulus
    int k;
    int rows;
    int cols;
    int cut;
    logic l;
    sb = new(PARITY_ROWS_MAX);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset shape k=1, n=2: one parity byte per data byte, data extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);

    // Three data shards, five parity rows
    set_shape(8'd3, 8'd8);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);

    // No parity rows: the column closes silently
    set_shape(8'd3, 8'd3);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h56, 1'b1);

    // Invalid setups drop input: k of zero, n below k, too many parity rows
    set_shape(8'd0, 8'd3);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    set_shape(8'd5, 8'd3);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h3C, 1'b0);
    set_shape(8'd1, 8'd18);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h0F, 1'b0);

    // Full parity width of 16 rows
    set_shape(8'd1, 8'd17);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);

    // Register extremes; the open column is discarded by the next write
    set_shape(8'd255, 8'd255);
    send_byte(8'hE7, 1'b0);
    send_byte(8'h18, 1'b1);
    send_byte(8'h99, 1'b0);

    // Random phases: mostly whole columns, some cut short, some bad setups
    while (fed < RANDOM_BYTES) begin
      steady_feed = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: begin
            k = $urandom_range(255, 1);
            set_shape(8'd0, 8'(k));
          end
          1: begin
            k = $urandom_range(200, 2);
            set_shape(8'(k), 8'($urandom_range(k - 1, 1)));
          end
          default: begin
            k = $urandom_range(200, 1);
            set_shape(8'(k), 8'(k + $urandom_range(55, 17)));
          end
        endcase
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom()), 1'($urandom()));
        continue;
      end
      k = $urandom_range(6, 1);
      cut = $urandom_range(99);
      rows = (cut < 15) ? 0 : (cut < 30) ? PARITY_ROWS_MAX : $urandom_range(8, 1);
      set_shape(8'(k), 8'(k + rows));
      cols = $urandom_range(6, 2);
      for (int c = 0; c < cols; c++) begin
        for (int j = 0; j < k; j++) begin
          l = (c == cols - 1) ? 1'b1 : ($urandom_range(7) == 0);
          send_byte(8'($urandom()), l);
          fed++;
        end
        // Pause the feed until the lanes have emptied
        if ($urandom_range(9) == 0) drain();
      end
      // Broken column: leave it open for the next write to discard
      if (k > 1 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(k - 1, 1)) begin
          send_byte(8'($urandom()), 1'($urandom()));
          fed++;
        end
      end
    end
    steady_feed = 1'b0;

    settle();
    $display("Fed %0d random data bytes after the directed set, %0d register writes.",
             fed, sb.writes);
    $display("Closed %0d columns and checked %0d parity bytes, %0d mismatches.",
             sb.columns, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### cauchy_rs_parity_encoder.f
sv/crs_pkg.sv
sv/crs_front.sv
sv/crs_fifo.sv
sv/crs_back.sv
sv/cauchy_rs_parity_encoder.sv
sim/parity_scoreboard_pkg.sv
sim/cauchy_rs_parity_encoder_tb.sv
